>>> design/svt_pkg.sv
// Shared types and constants for the sparse vector table unit.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
`timescale 1ns / 1ps

package svt_pkg;

   // Field widths of the request, response and register port.
   localparam int FUNC_W     = 2;
   localparam int INDEX_W    = 10;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   // Byte address of the null value register.
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_NULL_VALUE = 2'd0;

   // Operation codes carried in the request.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_SET    = 2'd2,
      FUNC_READ   = 2'd3
   } svt_func_type;

   // Completion codes carried in the response.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } svt_status_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_COMMIT
   } svt_state_type;

   // One table entry as kept in the entry memory.
   typedef struct packed {
      logic [INDEX_W-1:0]        position;
      logic signed [VALUE_W-1:0] data;
   } svt_entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;          // capture the accepted request
      logic scan_step;     // advance the table walk by one slot
      logic lookup_latch;  // keep the outcome of the table walk
      logic commit;        // update the table and load the response register
   } svt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic needs_scan;    // set or read with an index in range
      logic hit;           // the slot just read holds the requested position
      logic exhausted;     // every filled slot has been read without a hit
   } svt_stat_type;

endpackage

>>> design/svt_req_if.sv
// Request channel: valid/ready handshake with the operation, index and value.
// Depends on svt_pkg.
`timescale 1ns / 1ps

interface svt_req_if;
   import svt_pkg::*;

   logic                      valid;
   logic                      ready;
   svt_func_type              func;
   logic [INDEX_W-1:0]        index;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output func, output index, output value, input ready);
   modport sink   (input valid, input func, input index, input value, output ready);

endinterface

>>> design/svt_rsp_if.sv
// Response channel: valid/ready handshake with the read value and status.
// Depends on svt_pkg.
`timescale 1ns / 1ps

interface svt_rsp_if;
   import svt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] read_value;
   svt_status_type            status;

   modport source (output valid, output read_value, output status, input ready);
   modport sink   (input valid, input read_value, input status, output ready);

endinterface

>>> design/svt_ctrl.sv
// Controller of the sparse vector table unit: sequences load, table walk and commit.
// Owns the response valid flag. Depends on svt_pkg.
`timescale 1ns / 1ps

module svt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output svt_pkg::svt_cmd_type cmd,
   input  svt_pkg::svt_stat_type stat
);
   import svt_pkg::*;

   svt_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // State and response flag registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            // A new request may enter while the previous response still waits.
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = stat.needs_scan ? ST_SCAN : ST_COMMIT;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.hit || stat.exhausted) begin
               cmd.lookup_latch = 1'b1;
               state_in         = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // Finish only once the response register is free or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> design/svt_datapath.sv
// Datapath of the sparse vector table unit: entry memory, fill count, vector length,
// table walk and response register. Depends on svt_pkg.
`timescale 1ns / 1ps

module svt_datapath #(
   parameter int TABLE_DEPTH = 64,
   parameter int MAX_LENGTH  = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [svt_pkg::VALUE_W-1:0] null_value,
   input  svt_pkg::svt_func_type             req_func,
   input  logic [svt_pkg::INDEX_W-1:0]       req_index,
   input  logic signed [svt_pkg::VALUE_W-1:0] req_value,
   input  svt_pkg::svt_cmd_type              cmd,
   output svt_pkg::svt_stat_type             stat,
   output logic signed [svt_pkg::VALUE_W-1:0] rsp_read_value,
   output svt_pkg::svt_status_type           rsp_status
);
   import svt_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
   localparam int CMP_W  = (LEN_W > INDEX_W) ? LEN_W : INDEX_W;

   // Entry memory. Slots below the fill count are valid, since entries are only
   // ever added at the lowest free slot and removed all at once by clear.
   svt_entry_type entry_mem [TABLE_DEPTH];

   // Captured request.
   svt_func_type              func_ff;
   logic [INDEX_W-1:0]        index_ff;
   logic signed [VALUE_W-1:0] value_ff;

   // Vector state.
   logic [LEN_W-1:0] length_ff, length_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Table walk.
   logic [CNT_W-1:0]          scan_ff;
   logic                      rd_valid_ff;
   logic [ADDR_W-1:0]         rd_slot_ff;
   svt_entry_type             rd_word_ff;
   logic                      scan_issue;
   logic                      found_ff;
   logic [ADDR_W-1:0]         found_slot_ff;
   logic signed [VALUE_W-1:0] found_data_ff;

   // Commit results.
   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_waddr;
   svt_entry_type             mem_wdata;
   logic signed [VALUE_W-1:0] result_value;
   svt_status_type            result_status;
   logic signed [VALUE_W-1:0] read_value_ff;
   svt_status_type            status_ff;

   // Range and capacity checks.
   logic [CMP_W-1:0] len_ext, idx_ext;
   logic             index_out_of_range, length_at_max, table_full, value_is_null;

   assign len_ext            = CMP_W'(length_ff);
   assign idx_ext            = CMP_W'(index_ff);
   assign index_out_of_range = idx_ext >= len_ext;
   assign length_at_max      = length_ff >= LEN_W'(MAX_LENGTH);
   assign table_full         = count_ff == CNT_W'(TABLE_DEPTH);
   assign value_is_null      = value_ff == null_value;

   // Status toward the controller.
   assign scan_issue     = cmd.scan_step && (scan_ff < count_ff);
   assign stat.needs_scan = ((func_ff == FUNC_SET) || (func_ff == FUNC_READ))
                            && !index_out_of_range;
   assign stat.hit       = rd_valid_ff && (rd_word_ff.position == index_ff);
   assign stat.exhausted = !rd_valid_ff && (scan_ff == count_ff);

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         index_ff <= req_index;
         value_ff <= req_value;
      end
   end

   // Walk pointer and read pipeline flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         scan_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         rd_valid_ff <= scan_issue;
         if (scan_issue) begin
            scan_ff <= scan_ff + CNT_W'(1);
         end
      end
   end

   // Memory read port, one slot per cycle during the walk.
   always_ff @(posedge clock) begin
      if (scan_issue) begin
         rd_word_ff <= entry_mem[scan_ff[ADDR_W-1:0]];
         rd_slot_ff <= scan_ff[ADDR_W-1:0];
      end
   end

   // Outcome of the walk.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         found_ff <= 1'b0;
      end else if (cmd.lookup_latch) begin
         found_ff      <= stat.hit;
         found_slot_ff <= rd_slot_ff;
         found_data_ff <= rd_word_ff.data;
      end
   end

   // Effect of the operation on the table and the response.
   always_comb begin
      length_in          = length_ff;
      count_in           = count_ff;
      mem_we             = 1'b0;
      mem_waddr          = count_ff[ADDR_W-1:0];
      mem_wdata.position = index_ff;
      mem_wdata.data     = value_ff;
      result_value       = '0;
      result_status      = STATUS_OK;
      unique case (func_ff)
         FUNC_CLEAR: begin
            length_in = '0;
            count_in  = '0;
         end
         FUNC_APPEND: begin
            if (length_at_max) begin
               result_status = STATUS_RANGE;
            end else if (!value_is_null) begin
               if (table_full) begin
                  result_status = STATUS_FULL;
               end else begin
                  mem_we             = 1'b1;
                  mem_wdata.position = len_ext[INDEX_W-1:0];
                  count_in           = count_ff + CNT_W'(1);
                  length_in          = length_ff + LEN_W'(1);
               end
            end else begin
               // A null element only lengthens the vector.
               length_in = length_ff + LEN_W'(1);
            end
         end
         FUNC_SET: begin
            if (index_out_of_range) begin
               result_status = STATUS_RANGE;
            end else if (found_ff) begin
               mem_we    = 1'b1;
               mem_waddr = found_slot_ff;
            end else if (table_full) begin
               result_status = STATUS_FULL;
            end else begin
               mem_we   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         FUNC_READ: begin
            if (index_out_of_range) begin
               result_status = STATUS_RANGE;
            end else begin
               result_value = found_ff ? found_data_ff : null_value;
            end
         end
         default: begin
            result_status = STATUS_OK;
         end
      endcase
   end

   // Vector length and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         count_ff  <= '0;
      end else if (cmd.commit) begin
         length_ff <= length_in;
         count_ff  <= count_in;
      end
   end

   // Memory write port.
   always_ff @(posedge clock) begin
      if (cmd.commit && mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         read_value_ff <= result_value;
         status_ff     <= result_status;
      end
   end

   assign rsp_read_value = read_value_ff;
   assign rsp_status     = status_ff;

endmodule

>>> design/sparse_vector_table_unit.sv
// Sparse vector table unit: keeps a sparse vector as (index, value) entries in a table
// of TABLE_DEPTH slots plus a vector length of at most MAX_LENGTH; built from svt_pkg,
// svt_req_if, svt_rsp_if, svt_ctrl and svt_datapath. Requests are clear, append, set
// and read; each gives one response with a read value and a status. Set and read walk
// the filled slots of the entry memory, at most TABLE_DEPTH of them, one per cycle
// through its single registered read port, stopping at the first match. A new request
// is taken while the previous response still waits. Fill state clears at reset, so no
// initialization pass is needed. The null value register sits at byte address 0 of
// the register port; the user must write it only while the unit is idle, which the
// unit itself does not enforce.
`timescale 1ns / 1ps

module sparse_vector_table_unit #(
   parameter int TABLE_DEPTH = 64,
   parameter int MAX_LENGTH  = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   svt_req_if.sink                            req_if,
   svt_rsp_if.source                          rsp_if,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [svt_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [svt_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [svt_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import svt_pkg::*;

   logic signed [VALUE_W-1:0] null_value_ff;
   logic                      csr_write;
   logic                      csr_hit;
   svt_cmd_type               cmd;
   svt_stat_type              stat;

   // Register port: always ready, only the null value register is decoded.
   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr == CSR_ADDR_NULL_VALUE;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? null_value_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         null_value_ff <= '0;
      end else if (csr_write && csr_hit) begin
         null_value_ff <= csr_pwdata;
      end
   end

   // Sequencing.
   svt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Table storage and operation logic.
   svt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_LENGTH  (MAX_LENGTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .null_value     (null_value_ff),
      .req_func       (req_if.func),
      .req_index      (req_if.index),
      .req_value      (req_if.value),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_read_value (rsp_if.read_value),
      .rsp_status     (rsp_if.status)
   );

`ifndef SYNTHESIS
   // In the cycle after a request transfer the unit does not accept another request.
   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request accepted on two consecutive cycles");

   // A commit never overwrites a response that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_if.valid || rsp_if.ready))
      else $error("response register overwritten before transfer");

   // Every commit presents a response on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_if.valid)
      else $error("commit without a following response");
`endif

endmodule

>>> bench/sparse_vector_table_unit_test.sv
// Self-checking testbench for sparse_vector_table_unit: drives clear, append, set and read
// requests, rewrites the null value between phases and checks every response in order.
// Depends on svt_pkg, svt_req_if, svt_rsp_if and the unit itself.
`timescale 1ns / 1ps

module sparse_vector_table_unit_test;
   import svt_pkg::*;

   localparam int TABLE_SLOTS    = 64;
   localparam int MAX_VECTOR_LEN = 1024;
   localparam int ITEM_TARGET    = 1650;
   localparam int IDLE_PCT       = 15;

   // One response as the table should give it.
   typedef struct {
      logic signed [VALUE_W-1:0] read_value;
      svt_status_type            status;
   } vector_response_type;

   // Shadow copy of the table; predicts each response and checks them in order.
   class vector_table_scoreboard;
      logic signed [VALUE_W-1:0] null_value;
      logic [INDEX_W-1:0]        slot_position [TABLE_SLOTS];
      logic signed [VALUE_W-1:0] slot_data [TABLE_SLOTS];
      bit                        slot_filled [TABLE_SLOTS];
      int unsigned               length;
      vector_response_type       awaited [$];
      int unsigned               errors;

      function new();
         null_value = '0;
         length     = 0;
         errors     = 0;
         foreach (slot_filled[k]) slot_filled[k] = 1'b0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // Lowest empty slot, or -1 when the table is full.
      function int free_slot();
         for (int k = 0; k < TABLE_SLOTS; k++)
            if (!slot_filled[k]) return k;
         return -1;
      endfunction

      // Lowest filled slot holding the position, or -1 when it is absent.
      function int slot_of(logic [INDEX_W-1:0] pos);
         for (int k = 0; k < TABLE_SLOTS; k++)
            if (slot_filled[k] && slot_position[k] == pos) return k;
         return -1;
      endfunction

      // Apply one accepted request to the shadow table and queue its response.
      function void note_request(svt_func_type op, logic [INDEX_W-1:0] idx,
                                 logic signed [VALUE_W-1:0] val);
         vector_response_type r;
         int k;
         r.read_value = '0;
         r.status     = STATUS_OK;
         unique case (op)
            FUNC_CLEAR: begin
               foreach (slot_filled[j]) slot_filled[j] = 1'b0;
               length = 0;
            end
            FUNC_APPEND: begin
               if (length >= MAX_VECTOR_LEN) begin
                  r.status = STATUS_RANGE;
               end else if (val != null_value) begin
                  k = free_slot();
                  if (k < 0) begin
                     // The whole append is dropped, so the length holds.
                     r.status = STATUS_FULL;
                  end else begin
                     slot_filled[k]   = 1'b1;
                     slot_position[k] = INDEX_W'(length);
                     slot_data[k]     = val;
                     length++;
                  end
               end else begin
                  length++;
               end
            end
            FUNC_SET: begin
               if (idx >= length) begin
                  r.status = STATUS_RANGE;
               end else begin
                  k = slot_of(idx);
                  if (k < 0) k = free_slot();
                  if (k < 0) begin
                     r.status = STATUS_FULL;
                  end else begin
                     slot_filled[k]   = 1'b1;
                     slot_position[k] = idx;
                     slot_data[k]     = val;
                  end
               end
            end
            default: begin
               if (idx >= length) begin
                  r.status = STATUS_RANGE;
               end else begin
                  k = slot_of(idx);
                  r.read_value = (k < 0) ? null_value : slot_data[k];
               end
            end
         endcase
         awaited = {awaited, r};
      endfunction

      // Compare one response transfer against the oldest expectation.
      function void check_response(logic signed [VALUE_W-1:0] rv, svt_status_type st);
         vector_response_type r;
         if (awaited.size() == 0) begin
            $error("response: none expected, got read_value %0d status %0d", rv, st);
            errors++;
            return;
         end
         r = awaited.pop_front();
         if (rv !== r.read_value) begin
            $error("read_value: expected %0d, got %0d", r.read_value, rv);
            errors++;
         end
         if (st !== r.status) begin
            $error("status: expected %0d, got %0d", r.status, st);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   svt_req_if req_ch ();
   svt_rsp_if rsp_ch ();

   vector_table_scoreboard sb;
   int unsigned            issued = 0;
   bit                     steady = 1'b0;

   sparse_vector_table_unit #(
      .TABLE_DEPTH(TABLE_SLOTS),
      .MAX_LENGTH (MAX_VECTOR_LEN)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_ch),
      .rsp_if     (rsp_ch),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #6 clock = ~clock;

   // The receiver stalls at random unless a steady stretch is running.
   always @(posedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // Every response transfer is checked at the edge where it happens.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_response(rsp_ch.read_value, rsp_ch.status);
   end

   // Present one request, with random gaps ahead of it, and hold it until transfer.
   task automatic send_request(svt_func_type op, int unsigned idx,
                               logic signed [VALUE_W-1:0] val);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func  <= op;
      req_ch.index <= INDEX_W'(idx);
      req_ch.value <= val;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(op, INDEX_W'(idx), val);
      issued++;
   endtask

   // Hold the sender off until every outstanding response has been seen.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Register writes only happen with the unit idle: setup phase, then access phase.
   task automatic write_null_value(logic signed [VALUE_W-1:0] v);
      drain_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_NULL_VALUE;
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      sb.null_value = v;
   endtask

   // Mostly in range, sometimes right at the length, sometimes anywhere.
   function automatic int unsigned pick_index();
      int unsigned roll;
      roll = $urandom_range(99);
      if (sb.length == 0 || roll < 8) return $urandom_range(1023);
      if (roll < 14 && sb.length < MAX_VECTOR_LEN) return sb.length;
      return $urandom_range(sb.length - 1);
   endfunction

   function automatic logic signed [VALUE_W-1:0] element_value(int unsigned null_pct);
      if ($urandom_range(99) < null_pct) return sb.null_value;
      return $urandom;
   endfunction

   // A fresh vector built by appends, then a mix of sets, reads, appends and noise.
   task automatic run_short_phase(int unsigned appends, int unsigned null_pct,
                                  int unsigned ops);
      int unsigned roll;
      send_request(FUNC_CLEAR, $urandom_range(1023), $urandom);
      repeat (appends) send_request(FUNC_APPEND, $urandom_range(1023), element_value(null_pct));
      repeat (ops) begin
         roll = $urandom_range(99);
         if (roll < 40)
            send_request(FUNC_READ, pick_index(), $urandom);
         else if (roll < 75)
            send_request(FUNC_SET, pick_index(), element_value(15));
         else if (roll < 90)
            send_request(FUNC_APPEND, $urandom_range(1023), element_value(null_pct));
         else
            send_request(svt_func_type'($urandom_range(3)), $urandom_range(1023), $urandom);
      end
   endtask

   initial begin
      logic signed [VALUE_W-1:0] null_choices [4];
      int unsigned phase;
      null_choices = '{32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, 32'sd0};
      sb = new();
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.func  <= FUNC_CLEAR;
      req_ch.index <= '0;
      req_ch.value <= '0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty vector, extreme values, null stored by set, range edges, clear.
      write_null_value('0);
      send_request(FUNC_READ, 0, 0);
      send_request(FUNC_SET, 0, 7);
      send_request(FUNC_APPEND, 0, 0);
      send_request(FUNC_APPEND, 0, 32'sh7FFF_FFFF);
      send_request(FUNC_APPEND, 0, 32'sh8000_0000);
      send_request(FUNC_APPEND, 0, -32'sd1);
      send_request(FUNC_READ, 0, 0);
      send_request(FUNC_READ, 1, 0);
      send_request(FUNC_READ, 2, 0);
      send_request(FUNC_READ, 3, 0);
      send_request(FUNC_SET, 0, 5);
      send_request(FUNC_SET, 1, 0);
      send_request(FUNC_READ, 1, 0);
      send_request(FUNC_READ, 0, 0);
      send_request(FUNC_READ, 4, 0);
      send_request(FUNC_READ, 1023, 0);
      send_request(FUNC_SET, 1023, -32'sd1);
      send_request(FUNC_CLEAR, 1023, -32'sd1);
      send_request(FUNC_READ, 0, 0);
      send_request(FUNC_APPEND, 1023, 0);

      // Random phases: the first overfills the table, the third runs to full length.
      phase = 0;
      while (issued < ITEM_TARGET) begin
         if (phase < 4)
            write_null_value(null_choices[phase]);
         else if ($urandom_range(1) == 0)
            write_null_value($urandom);
         else
            drain_results();
         if (phase == 0) begin
            run_short_phase(90, 15, 60);
         end else if (phase == 2) begin
            // Long vector with few stored entries and no idling on either side.
            send_request(FUNC_CLEAR, $urandom_range(1023), $urandom);
            steady = 1'b1;
            repeat (MAX_VECTOR_LEN + 6) begin
               send_request(FUNC_APPEND, $urandom_range(1023), element_value(97));
               if ($urandom_range(99) < 3)
                  send_request(FUNC_READ, pick_index(), $urandom);
            end
            steady = 1'b0;
            repeat (40)
               send_request(svt_func_type'($urandom_range(1) ? FUNC_SET : FUNC_READ),
                            pick_index(), element_value(15));
         end else begin
            run_short_phase($urandom_range(5, 85), $urandom_range(10, 70),
                            $urandom_range(20, 80));
         end
         phase++;
      end

      drain_results();
      repeat (80) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> sim.f
design/svt_pkg.sv
design/svt_req_if.sv
design/svt_rsp_if.sv
design/svt_ctrl.sv
design/svt_datapath.sv
design/sparse_vector_table_unit.sv
bench/sparse_vector_table_unit_test.sv
